// ----- sv/char_set_jaccard_similarity_defines.svh -----
// Assertion macros for the character-set Jaccard similarity block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef CHAR_SET_JACCARD_SIMILARITY_DEFINES_SVH
`define CHAR_SET_JACCARD_SIMILARITY_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define CJS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define CJS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/cjs_pkg.sv -----
// Shared types and constants for the character-set Jaccard similarity block.
// Depends on nothing.
package cjs_pkg;

    localparam int CH_W   = 8;   // byte field
    localparam int FUNC_W = 2;   // selector field
    localparam int SIM_W  = 7;   // percentage result
    localparam int CNT_W  = 9;   // shared and union counts, 0..256
    localparam int REM_W  = 15;  // 100 * shared, up to 25600
    localparam int OUT_W  = 32;  // result tdata, padded to whole bytes

    localparam int unsigned PCT_SCALE = 100;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ADD_FIRST  = 2'd0,
        FUNC_ADD_SECOND = 2'd1,
        FUNC_FINISH     = 2'd2,
        FUNC_NONE       = 2'd3
    } func_t;

endpackage

// ----- sv/char_set_jaccard_similarity.sv -----
// Top level of the character-set Jaccard similarity block: set storage,
// bit-serial count walk and shift-subtract percentage divider.
// Depends on cjs_pkg and char_set_jaccard_similarity_defines.svh.
//
//  channel | ports                          | contents
//  --------+--------------------------------+---------------------------------
//  input   | s_tvalid s_tready s_tdata s_tuser | ch in tdata, func in tuser
//  result  | m_tvalid m_tready m_tdata      | similarity, shared, union counts
//
// A finish request walks the sets one bit per cycle through their shift
// registers, then the shared count is scaled and divided by restoring steps.
// Reset clears both sets at once. A waiting result does not block add
// requests; a finished division holds until the result register is free.
`include "char_set_jaccard_similarity_defines.svh"

module char_set_jaccard_similarity
    import cjs_pkg::*;
#(
    parameter int ALPHABET_SIZE = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [CH_W-1:0]     s_tdata,   // [7:0] ch
    input  logic [FUNC_W-1:0]   s_tuser,   // [1:0] func
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata    // [6:0] similarity, [15:7] shared_count,
                                           // [24:16] union_count, [31:25] zero
);

    localparam int IDX_W  = $clog2(ALPHABET_SIZE);
    localparam int STEP_W = $clog2(SIM_W);
    localparam int PAD_W  = OUT_W - SIM_W - 2 * CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_PREP,
        S_DIV,
        S_DONE
    } state_t;

    state_t                   state_reg, state_next;
    logic [ALPHABET_SIZE-1:0] first_set_reg, first_set_next;
    logic [ALPHABET_SIZE-1:0] second_set_reg, second_set_next;
    logic [IDX_W-1:0]         walk_cnt_reg, walk_cnt_next;
    logic [CNT_W-1:0]         shared_reg, shared_next;
    logic [CNT_W-1:0]         union_reg, union_next;
    logic [REM_W-1:0]         rem_reg, rem_next;
    logic [REM_W-1:0]         dsr_reg, dsr_next;
    logic [SIM_W-1:0]         quo_reg, quo_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     m_tvalid_reg, m_tvalid_next;
    logic [SIM_W-1:0]         sim_reg, sim_next;
    logic [CNT_W-1:0]         out_shared_reg, out_shared_next;
    logic [CNT_W-1:0]         out_union_reg, out_union_next;

    logic                     s_fire;
    logic                     in_alpha;
    logic [ALPHABET_SIZE-1:0] byte_mask;
    logic                     rem_ge;

    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign in_alpha = ({1'b0, s_tdata} < CNT_W'(ALPHABET_SIZE));
    assign byte_mask = ALPHABET_SIZE'(1) << s_tdata[IDX_W-1:0];
    assign rem_ge   = (rem_reg >= dsr_reg);

    always_comb begin
        state_next      = state_reg;
        first_set_next  = first_set_reg;
        second_set_next = second_set_reg;
        walk_cnt_next   = walk_cnt_reg;
        shared_next     = shared_reg;
        union_next      = union_reg;
        rem_next        = rem_reg;
        dsr_next        = dsr_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        m_tvalid_next   = m_tvalid_reg;
        sim_next        = sim_reg;
        out_shared_next = out_shared_reg;
        out_union_next  = out_union_reg;

        // drop the result once taken
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    case (func_t'(s_tuser))
                        FUNC_ADD_FIRST: begin
                            if (in_alpha) begin
                                first_set_next = first_set_reg | byte_mask;
                            end
                        end
                        FUNC_ADD_SECOND: begin
                            if (in_alpha) begin
                                second_set_next = second_set_reg | byte_mask;
                            end
                        end
                        FUNC_FINISH: begin
                            shared_next   = '0;
                            union_next    = '0;
                            walk_cnt_next = IDX_W'(ALPHABET_SIZE - 1);
                            state_next    = S_WALK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_WALK: begin
                // count the low bit of each set, shift zeros in to clear
                shared_next = shared_reg + CNT_W'(first_set_reg[0] & second_set_reg[0]);
                union_next  = union_reg + CNT_W'(first_set_reg[0] | second_set_reg[0]);
                first_set_next  = first_set_reg >> 1;
                second_set_next = second_set_reg >> 1;
                walk_cnt_next   = walk_cnt_reg - 1'b1;
                if (walk_cnt_reg == '0) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                // scale the shared count, align the divisor to the top quotient bit
                rem_next  = REM_W'(shared_reg * PCT_SCALE);
                dsr_next  = REM_W'({union_reg, {(SIM_W-1){1'b0}}});
                quo_next  = '0;
                step_next = STEP_W'(SIM_W - 1);
                state_next = S_DIV;
            end
            S_DIV: begin
                // one restoring step per cycle
                if (rem_ge) begin
                    rem_next = rem_reg - dsr_reg;
                end
                quo_next = {quo_reg[SIM_W-2:0], rem_ge};
                dsr_next = dsr_reg >> 1;
                step_next = step_reg - 1'b1;
                if (step_reg == '0) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the result register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    sim_next        = (union_reg == '0) ? '0 : quo_reg;
                    out_shared_next = shared_reg;
                    out_union_next  = union_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            first_set_reg  <= '0;
            second_set_reg <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            first_set_reg  <= first_set_next;
            second_set_reg <= second_set_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
        walk_cnt_reg   <= walk_cnt_next;
        shared_reg     <= shared_next;
        union_reg      <= union_next;
        rem_reg        <= rem_next;
        dsr_reg        <= dsr_next;
        quo_reg        <= quo_next;
        step_reg       <= step_next;
        sim_reg        <= sim_next;
        out_shared_reg <= out_shared_next;
        out_union_reg  <= out_union_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_union_reg, out_shared_reg, sim_reg};

    // both sets are empty once the walk has finished
    `CJS_ASSERT_NOW(a_sets_cleared, aclk, aresetn, state_reg == S_PREP,
        first_set_reg == '0 && second_set_reg == '0, "sets not cleared after walk")

    // shared count never exceeds union count
    `CJS_ASSERT_NOW(a_shared_le_union, aclk, aresetn, state_reg == S_WALK,
        shared_reg <= union_reg, "shared count above union count")

    // percentage stays in range
    `CJS_ASSERT_NOW(a_sim_range, aclk, aresetn, m_tvalid_reg,
        sim_reg <= SIM_W'(PCT_SCALE) && out_shared_reg <= out_union_reg,
        "result out of range")

    // a new result comes only out of the done state
    `CJS_ASSERT_NOW(a_load_from_done, aclk, aresetn, $rose(m_tvalid_reg),
        $past(state_reg) == S_DONE, "result raised outside done state")

endmodule
